/* design/assert_macros.svh */
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* design/dtfs_pkg.sv */
// Shared constants, codes and control structs of the text field splitter.
package dtfs_pkg;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int COL_W    = 5;
    localparam int CCNT_W   = 6;
    localparam int STAT_W   = 2;
    localparam int LINE_W   = 21;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 21;

    localparam logic [CCNT_W-1:0] MAX_COLUMNS  = 6'd32;
    localparam logic [CCNT_W-1:0] MIN_COLUMNS  = 6'd2;
    localparam logic [CCNT_W-1:0] COL_SAT      = 6'h3F;
    localparam logic [LINE_W-1:0] LINE_SAT     = 21'h1FFFFF;
    localparam logic [LINE_W-1:0] LINE_NUM_MAX = 21'd1048576;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_FIELD_BYTE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIELD_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NULL_COL   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LINE_END   = 2'd3;

    // line status codes
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_SHORT = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_LONG  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_DELIM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_DELIM   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COLUMNS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LINES    = 2'd3;

    localparam logic [BYTE_W-1:0] FIELD_DELIM_RST  = 8'd9;
    localparam logic [BYTE_W-1:0] LINE_DELIM_RST   = 8'd10;
    localparam logic [LINE_W-1:0] MAX_LINES_RST    = 21'd1048576;

    // controller -> datapath
    typedef struct packed {
        logic              out_load;
        logic [KIND_W-1:0] kind;
        logic              last;
        logic              col_inc;
        logic              line_start;
        logic              line_done;
    } dtfs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_field;
        logic is_line;
        logic col_lt;
        logic out_free;
    } dtfs_stat_t;

endpackage

/* design/dtfs_ctrl.sv */
// Controller: sequences field, null and line-end results per input byte.
module dtfs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dtfs_pkg::dtfs_stat_t stat,
    output dtfs_pkg::dtfs_cmd_t  cmd
);
    import dtfs_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_BUSY = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    assign s_ready = (state_reg == ST_IDLE) && stat.out_free;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.kind       = KIND_FIELD_BYTE;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!stat.is_field) begin
                        cmd.out_load = stat.col_lt;
                        cmd.kind     = KIND_FIELD_BYTE;
                        cmd.last     = 1'b1;
                    end else begin
                        cmd.col_inc  = 1'b1;
                        cmd.out_load = stat.col_lt;
                        cmd.kind     = KIND_FIELD_END;
                        cmd.last     = !stat.is_line;
                        if (stat.is_line) begin
                            cmd.line_start = 1'b1;
                            state_next     = ST_BUSY;
                        end
                    end
                end
            end
            ST_BUSY: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    if (stat.col_lt) begin
                        cmd.kind    = KIND_NULL_COL;
                        cmd.col_inc = 1'b1;
                    end else begin
                        cmd.kind      = KIND_LINE_END;
                        cmd.last      = 1'b1;
                        cmd.line_done = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/dtfs_dp.sv */
// Datapath: config registers, column and line counters, result register.
module dtfs_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [dtfs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dtfs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [dtfs_pkg::BYTE_W-1:0]          s_text_byte,
    input  dtfs_pkg::dtfs_cmd_t                  cmd,
    output dtfs_pkg::dtfs_stat_t                 stat,
    input  logic                                 m_ready,
    output logic                                 m_valid,
    output logic [dtfs_pkg::KIND_W-1:0]          m_kind,
    output logic [dtfs_pkg::COL_W-1:0]           m_column,
    output logic [dtfs_pkg::BYTE_W-1:0]          m_data_byte,
    output logic [dtfs_pkg::STAT_W-1:0]          m_line_status,
    output logic                                 m_too_many_lines,
    output logic [dtfs_pkg::LINE_W-1:0]          m_line_number,
    output logic                                 m_last
);
    import dtfs_pkg::*;

    logic [BYTE_W-1:0] field_delim_reg;
    logic [BYTE_W-1:0] line_delim_reg;
    logic [CCNT_W-1:0] line_columns_reg;
    logic [LINE_W-1:0] max_lines_reg;

    logic [CCNT_W-1:0] col_cnt_reg;
    logic [CCNT_W-1:0] col_cnt_next;
    logic [LINE_W-1:0] line_cnt_reg;
    logic [LINE_W-1:0] line_cnt_next;
    logic [STAT_W-1:0] lstat_reg;
    logic              zero_reg;
    logic              out_valid_reg;

    logic [KIND_W-1:0] kind_reg;
    logic [COL_W-1:0]  column_reg;
    logic [BYTE_W-1:0] data_reg;
    logic [STAT_W-1:0] status_reg;
    logic              flag_reg;
    logic [LINE_W-1:0] lnum_reg;
    logic              last_reg;

    logic [CCNT_W-1:0] eff_cols;
    logic [COL_W-1:0]  data_cols;
    logic [CCNT_W-1:0] col_inc_val;
    logic [LINE_W-1:0] line_inc_val;
    logic              is_zero;
    logic              flag_now;
    logic              flag_end;
    logic              is_end;

    // clamp column register to [2, MAX_COLUMNS]
    always_comb begin
        if (line_columns_reg < MIN_COLUMNS) begin
            eff_cols = MIN_COLUMNS;
        end else if (line_columns_reg > MAX_COLUMNS) begin
            eff_cols = MAX_COLUMNS;
        end else begin
            eff_cols = line_columns_reg;
        end
    end
    assign data_cols = COL_W'(eff_cols - 6'd1);

    assign col_inc_val  = (col_cnt_reg == COL_SAT) ? col_cnt_reg : col_cnt_reg + 6'd1;
    assign line_inc_val = (line_cnt_reg == LINE_SAT) ? line_cnt_reg : line_cnt_reg + 21'd1;

    assign is_zero       = (s_text_byte == '0);
    assign stat.is_line  = is_zero || (s_text_byte == line_delim_reg);
    assign stat.is_field = stat.is_line || (s_text_byte == field_delim_reg);
    assign stat.col_lt   = col_cnt_reg < {1'b0, data_cols};
    assign stat.out_free = !out_valid_reg || m_ready;

    assign flag_now = line_cnt_reg > max_lines_reg;
    // line_count + 1 > max_lines
    assign flag_end = line_cnt_reg >= max_lines_reg;
    assign is_end   = (cmd.kind == KIND_LINE_END);

    always_comb begin
        col_cnt_next  = col_cnt_reg;
        line_cnt_next = line_cnt_reg;
        if (cmd.col_inc) begin
            col_cnt_next = col_inc_val;
        end
        if (cmd.line_done) begin
            col_cnt_next  = '0;
            line_cnt_next = zero_reg ? '0 : line_inc_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_delim_reg  <= FIELD_DELIM_RST;
            line_delim_reg   <= LINE_DELIM_RST;
            line_columns_reg <= MAX_COLUMNS;
            max_lines_reg    <= MAX_LINES_RST;
            col_cnt_reg      <= '0;
            line_cnt_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_FIELD_DELIM:  field_delim_reg  <= cfg_data[BYTE_W-1:0];
                    REG_LINE_DELIM:   line_delim_reg   <= cfg_data[BYTE_W-1:0];
                    REG_LINE_COLUMNS: line_columns_reg <= cfg_data[CCNT_W-1:0];
                    REG_MAX_LINES:    max_lines_reg    <= cfg_data[LINE_W-1:0];
                    default: ;
                endcase
            end
            col_cnt_reg  <= col_cnt_next;
            line_cnt_reg <= line_cnt_next;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // line bookkeeping captured with the delimiter byte
    always_ff @(posedge aclk) begin
        if (cmd.line_start) begin
            zero_reg <= is_zero;
            if (col_inc_val < {1'b0, data_cols}) begin
                lstat_reg <= STATUS_SHORT;
            end else if (col_inc_val == {1'b0, data_cols}) begin
                lstat_reg <= STATUS_OK;
            end else begin
                lstat_reg <= STATUS_LONG;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            kind_reg   <= cmd.kind;
            column_reg <= is_end ? data_cols : col_cnt_reg[COL_W-1:0];
            data_reg   <= (cmd.kind == KIND_FIELD_BYTE) ? s_text_byte : '0;
            status_reg <= is_end ? lstat_reg : STATUS_OK;
            flag_reg   <= is_end ? flag_end : flag_now;
            lnum_reg   <= (line_cnt_reg > LINE_NUM_MAX) ? LINE_NUM_MAX : line_cnt_reg;
            last_reg   <= cmd.last;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = kind_reg;
    assign m_column         = column_reg;
    assign m_data_byte      = data_reg;
    assign m_line_status    = status_reg;
    assign m_too_many_lines = flag_reg;
    assign m_line_number    = lnum_reg;
    assign m_last           = last_reg;

endmodule

/* design/delimited_text_field_splitter.sv */
// Top level: delimited text splitter, byte stream in, tagged field results out.
// A byte's first result, if any, is loaded into the output register when the byte is taken.
// Throughput: one cycle per plain or field-delimiter byte while the output register is free;
// a line delimiter holds off input while the controller emits nulls and the line end serially.
// Reset (aresetn low, synchronous): counters cleared, registers to defaults, output empty.
module delimited_text_field_splitter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dtfs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dtfs_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input byte channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [dtfs_pkg::BYTE_W-1:0]          s_text_byte,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [dtfs_pkg::KIND_W-1:0]          m_kind,
    output logic [dtfs_pkg::COL_W-1:0]           m_column,
    output logic [dtfs_pkg::BYTE_W-1:0]          m_data_byte,
    output logic [dtfs_pkg::STAT_W-1:0]          m_line_status,
    output logic                                 m_too_many_lines,
    output logic [dtfs_pkg::LINE_W-1:0]          m_line_number,
    output logic                                 m_last
);
    import dtfs_pkg::*;

    dtfs_cmd_t  cmd;
    dtfs_stat_t stat;

    // The user must issue config writes only while idle; the block does not enforce this and always takes them.
    assign cfg_ready = 1'b1;

    // Controller: IDLE takes a byte whenever the output register is free or
    // being drained this cycle; a line delimiter or zero byte moves it to BUSY, where it
    // pads missing columns with nulls and then issues the line-end transaction.
    dtfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: delimiter compare, column/line counters (saturating), line
    // status capture, and the single output register that decouples the
    // result side from the input side.
    dtfs_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_text_byte      (s_text_byte),
        .cmd              (cmd),
        .stat             (stat),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_kind           (m_kind),
        .m_column         (m_column),
        .m_data_byte      (m_data_byte),
        .m_line_status    (m_line_status),
        .m_too_many_lines (m_too_many_lines),
        .m_line_number    (m_line_number),
        .m_last           (m_last)
    );

endmodule

/* design/dtfs_checker.sv */
// Port-level checker for the text field splitter, bound to the top level.
`include "assert_macros.svh"

module dtfs_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [dtfs_pkg::KIND_W-1:0]     m_kind,
    input  logic [dtfs_pkg::BYTE_W-1:0]     m_data_byte,
    input  logic [dtfs_pkg::STAT_W-1:0]     m_line_status,
    input  logic                            m_last
);
    import dtfs_pkg::*;

    // stalled result transaction holds its kind
    `ASSERT_NEXT(a_hold_kind, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_kind))
    // a line end always closes the results of its byte
    `ASSERT_NOW(a_end_last, aclk, aresetn, m_valid && m_kind == KIND_LINE_END, m_last)
    // a field byte is the only result of its byte
    `ASSERT_NOW(a_byte_last, aclk, aresetn, m_valid && m_kind == KIND_FIELD_BYTE, m_last)
    // status only on line ends
    `ASSERT_NOW(a_status_zero, aclk, aresetn, m_valid && m_kind != KIND_LINE_END,
                m_line_status == STATUS_OK)
    // data only on field bytes
    `ASSERT_NOW(a_data_zero, aclk, aresetn, m_valid && m_kind != KIND_FIELD_BYTE,
                m_data_byte == '0)

endmodule

bind delimited_text_field_splitter dtfs_checker u_dtfs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_kind        (m_kind),
    .m_data_byte   (m_data_byte),
    .m_line_status (m_line_status),
    .m_last        (m_last)
);
